[src/assert_macros.svh]
// Assertion macros shared by the RTL of the transaction status log.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked implication check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that is live through reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[src/tsl_pkg.sv]
// Types and codes for the transaction status log.
// No dependencies; imported by transaction_status_log.
package tsl_pkg;

   localparam int XID_W = 32;

   // request kinds
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   // status codes
   localparam logic [1:0] STAT_INPROG = 2'd0;
   localparam logic [1:0] STAT_ABORT  = 2'd1;
   localparam logic [1:0] STAT_SOFT   = 2'd2;
   localparam logic [1:0] STAT_COMMIT = 2'd3;

   // error codes
   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_XID     = 2'd1;
   localparam logic [1:0] ERR_WINDOW  = 2'd2;
   localparam logic [1:0] ERR_PROTECT = 2'd3;

   // sequencer states
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_LOOK  = 2'd2;
   localparam logic [1:0] S_MOD   = 2'd3;

   typedef logic [1:0] status_type;
   typedef logic [1:0] error_type;

   // classification of a request, worked out while the entry is read
   typedef struct packed {
      logic xid_zero;
      logic below;
      logic outside;
      logic protect;
   } lookup_type;

endpackage

[src/transaction_status_log.sv]
// Transaction status log: 2-bit status per transaction id in one on-chip store.
// Steps: request registered, entry read in LOOK, response registered in MOD
// (held there while the response output stalls). No new request is taken
// until the single read-modify-write pass over the store (accept, address and
// read, modify and write back) is through. Reset: clears the store to in
// progress, one entry a cycle, with requests stalled; csr writes taken.
`include "assert_macros.svh"

module transaction_status_log #(
   parameter int ENTRIES_PER_BLOCK = 1024,   // power of two
   parameter int NUM_BLOCKS        = 4,
   parameter int unsigned AMI_XID  = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [31:0]                csr_low_water_mark,
   // requests
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_type,
   input  logic [31:0]                req_xid,
   input  tsl_pkg::status_type        req_new_status,
   // responses
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tsl_pkg::status_type        rsp_status,
   output tsl_pkg::error_type         rsp_error
);
   import tsl_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES_PER_BLOCK);
   localparam int PAGE_W = XID_W - SLOT_W;
   localparam int PG_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int ADDR_W = PG_W + SLOT_W;
   localparam int DEPTH  = ENTRIES_PER_BLOCK * NUM_BLOCKS;
   localparam logic [PAGE_W-1:0] NB_PAGES  = PAGE_W'(NUM_BLOCKS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [XID_W-1:0]  AMI_W     = XID_W'(AMI_XID);

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff;
   logic [XID_W-1:0]  lwm_ff;

   logic              type_ff;
   logic [XID_W-1:0]  xid_ff;
   status_type        want_ff;
   lookup_type        lkp_ff, lkp_in;

   logic [1:0]        store_mem [DEPTH];
   status_type        rd_data_ff;
   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_raddr, mem_waddr;
   status_type        mem_wdata;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff, rsp_status_in;
   error_type         rsp_error_ff, rsp_error_in;
   logic              rsp_load, slot_free, set_write;

   logic [PAGE_W-1:0] abs_page, base_page, page_diff;
   status_type        old_st, next_st;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_error = rsp_error_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // locate the entry while the request sits in LOOK
   always_comb begin
      abs_page       = xid_ff[XID_W-1:SLOT_W];
      base_page      = lwm_ff[XID_W-1:SLOT_W];
      page_diff      = abs_page - base_page;
      lkp_in.xid_zero = (xid_ff == '0);
      lkp_in.below    = (xid_ff < lwm_ff);
      lkp_in.outside  = (abs_page < base_page) || (page_diff >= NB_PAGES);
      lkp_in.protect  = (xid_ff == AMI_W) && (lwm_ff <= AMI_W);
      mem_raddr       = {page_diff[PG_W-1:0], xid_ff[SLOT_W-1:0]};
      mem_re          = (state_ff == S_LOOK);
   end

   // modify the entry read back and form the response
   always_comb begin
      old_st        = rd_data_ff;
      next_st       = (want_ff == STAT_SOFT) ? (old_st | STAT_SOFT) : want_ff;
      rsp_status_in = STAT_INPROG;
      rsp_error_in  = ERR_OK;
      set_write     = 1'b0;
      if (type_ff == REQ_GET) begin
         if (lkp_ff.xid_zero) begin
            rsp_error_in = ERR_XID;
         end else if (lkp_ff.below) begin
            rsp_status_in = STAT_COMMIT;
         end else if (lkp_ff.outside) begin
            rsp_status_in = STAT_ABORT;
         end else begin
            rsp_status_in = old_st;
         end
      end else begin
         if (lkp_ff.below || lkp_ff.outside) begin
            rsp_error_in = ERR_WINDOW;
         end else if (lkp_ff.protect && (old_st != STAT_INPROG)
                      && (next_st == STAT_INPROG)) begin
            rsp_status_in = old_st;
            rsp_error_in  = ERR_PROTECT;
         end else begin
            rsp_status_in = next_st;
            set_write     = 1'b1;
         end
      end
   end

   assign rsp_load = (state_ff == S_MOD) && slot_free;

   always_comb begin
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = STAT_INPROG;
      end else begin
         mem_we    = rsp_load && set_write;
         mem_waddr = mem_raddr;
         mem_wdata = next_st;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == LAST_ADDR) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_LOOK;
         S_LOOK:  state_in = S_MOD;
         S_MOD:   if (slot_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_valid && csr_ready) lwm_ff <= csr_low_water_mark;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold the request, the lookup and the response
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         type_ff <= req_type;
         xid_ff  <= req_xid;
         want_ff <= req_new_status;
      end
      if (state_ff == S_LOOK) lkp_ff <= lkp_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_error_ff  <= rsp_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= store_mem[mem_raddr];
   end

   `ASSERT_CLK(a_accept_to_look, clock, reset,
      (req_valid && !req_stall) |=> (state_ff == S_LOOK),
      "accepted request did not move to lookup")
   `ASSERT_CLK(a_look_to_mod, clock, reset,
      (state_ff == S_LOOK) |=> (state_ff == S_MOD),
      "lookup not followed by modify")
   `ASSERT_CLK(a_get_no_write, clock, reset,
      (state_ff == S_MOD && mem_we) |-> (type_ff == REQ_SET),
      "store written on a get")
   `ASSERT_CLK(a_refuse_no_write, clock, reset,
      (rsp_load && (rsp_error_in == ERR_PROTECT || rsp_error_in == ERR_WINDOW)) |-> !mem_we,
      "store written on a refused set")
   `ASSERT_ALWAYS(a_rsp_from_mod, clock,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_MOD),
      "response raised outside modify")

endmodule
